### design/ratalu_pkg.sv
// shared types and constants of the rational alu with reduction
// no dependencies
package ratalu_pkg;

   localparam logic [2:0] FUNC_NORM = 3'd0;
   localparam logic [2:0] FUNC_ADD  = 3'd1;
   localparam logic [2:0] FUNC_SUB  = 3'd2;
   localparam logic [2:0] FUNC_MUL  = 3'd3;
   localparam logic [2:0] FUNC_DIV  = 3'd4;

   localparam logic [63:0] NUM_POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] NUM_NEG_LIMIT = 64'h0000_0000_8000_0000;
   localparam logic [63:0] DEN_LIMIT     = 64'h0000_0000_3FFF_FFFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_COMB,
      S_SIGN,
      S_GCD,
      S_DIVN,
      S_DIVD,
      S_SAT,
      S_OUT
   } state_type;

endpackage

### design/rational_alu_with_reduction.sv
// top level of the rational alu with reduction: handshake, sequencer, datapath
// depends on ratalu_pkg, ratalu_mul, ratalu_gcd, ratalu_div
//
// One request at a time: the block takes a request, forms four cross products on a
// single multiplier, combines and fixes the sign, reduces with a binary gcd unit
// (one step per cycle, the step count depends on the operands) and divides numerator
// and denominator by the gcd on a restoring divider. A zero numerator or a zero
// denominator skips the gcd unit and the divider. req_tready is low from acceptance
// until the response has been taken.
module rational_alu_with_reduction
   import ratalu_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // a_num, a_den, b_num, b_den
   input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] req_tdata,
   // func
   input  logic [2:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // res_num, res_den
   output logic [63:0]                   rsp_tdata,
   // status
   output logic                          rsp_tuser
);

   localparam int W  = OPERAND_WIDTH;
   localparam int MW = 2 * W;
   localparam int SW = 2 * W + 1;

   state_type state_ff, state_in;

   logic [2:0]            func_ff, func_in;
   logic signed [W-1:0]   an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [MW-1:0]  p_ff [4];
   logic [2:0]            cnt_ff, cnt_in;
   logic signed [SW-1:0]  n_ff, n_in, d_ff, d_in;
   logic [MW-1:0]         nm_ff, nm_in, dm_ff, dm_in, g_ff, g_in, qn_ff, qn_in, qd_ff, qd_in;
   logic                  neg_ff, neg_in, err_ff, err_in;
   logic [31:0]           num_ff, num_in;
   logic [29:0]           den_ff, den_in;

   logic signed [W-1:0]   mul_a, mul_b;
   logic signed [MW-1:0]  prod;
   logic                  gcd_start, gcd_done, div_start, div_done;
   logic [MW-1:0]         gcd_g, div_dividend, div_divisor, div_q;
   logic signed [SW-1:0]  n_fix, d_fix;
   logic [63:0]           qn_x, qd_x;

   ratalu_mul #(.W(W)) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   ratalu_gcd #(.MW(MW)) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .x_init (nm_in),
      .y_init (dm_in),
      .done   (gcd_done),
      .g      (gcd_g)
   );

   ratalu_div #(.MW(MW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      unique case (cnt_ff)
         3'd1:    begin mul_a = ad_ff; mul_b = bn_ff; end
         3'd2:    begin mul_a = ad_ff; mul_b = bd_ff; end
         3'd3:    begin mul_a = an_ff; mul_b = bn_ff; end
         default: begin mul_a = an_ff; mul_b = bd_ff; end
      endcase
   end

   assign div_dividend = (state_ff == S_GCD) ? nm_ff : dm_ff;
   assign div_divisor  = (state_ff == S_GCD) ? gcd_g : g_ff;

   assign n_fix = d_ff[SW-1] ? -n_ff : n_ff;
   assign d_fix = d_ff[SW-1] ? -d_ff : d_ff;
   assign qn_x  = 64'(qn_ff);
   assign qd_x  = 64'(qd_ff);

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      bn_in     = bn_ff;
      bd_in     = bd_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      nm_in     = nm_ff;
      dm_in     = dm_ff;
      g_in      = g_ff;
      qn_in     = qn_ff;
      qd_in     = qd_ff;
      neg_in    = neg_ff;
      err_in    = err_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      gcd_start = 1'b0;
      div_start = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in  = req_tuser;
               an_in    = req_tdata[W-1:0];
               ad_in    = req_tdata[2*W-1:W];
               bn_in    = req_tdata[3*W-1:2*W];
               bd_in    = req_tdata[4*W-1:3*W];
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            unique case (func_ff)
               FUNC_ADD: begin
                  n_in = SW'(p_ff[0]) + SW'(p_ff[1]);
                  d_in = SW'(p_ff[2]);
               end
               FUNC_SUB: begin
                  n_in = SW'(p_ff[0]) - SW'(p_ff[1]);
                  d_in = SW'(p_ff[2]);
               end
               FUNC_MUL: begin
                  n_in = SW'(p_ff[3]);
                  d_in = SW'(p_ff[2]);
               end
               FUNC_DIV: begin
                  n_in = SW'(p_ff[0]);
                  d_in = SW'(p_ff[1]);
               end
               default: begin
                  n_in = SW'(an_ff);
                  d_in = SW'(ad_ff);
               end
            endcase
            state_in = S_SIGN;
         end
         S_SIGN: begin
            neg_in = n_fix[SW-1];
            nm_in  = n_fix[SW-1] ? MW'(-n_fix) : MW'(n_fix);
            dm_in  = MW'(d_fix);
            err_in = (d_ff == '0);
            if (d_ff == '0) begin
               qn_in    = '0;
               qd_in    = '0;
               state_in = S_SAT;
            end else if (n_ff == '0) begin
               qn_in    = '0;
               qd_in    = MW'(d_fix);
               state_in = S_SAT;
            end else begin
               gcd_start = 1'b1;
               state_in  = S_GCD;
            end
         end
         S_GCD: begin
            if (gcd_done) begin
               g_in      = gcd_g;
               div_start = 1'b1;
               state_in  = S_DIVN;
            end
         end
         S_DIVN: begin
            if (div_done) begin
               qn_in     = div_q;
               div_start = 1'b1;
               state_in  = S_DIVD;
            end
         end
         S_DIVD: begin
            if (div_done) begin
               qd_in    = div_q;
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (neg_ff) begin
               num_in = (qn_x > NUM_NEG_LIMIT) ? 32'h8000_0000 : -qn_x[31:0];
            end else begin
               num_in = (qn_x > NUM_POS_LIMIT) ? 32'h7FFF_FFFF : qn_x[31:0];
            end
            den_in = (qd_x > DEN_LIMIT) ? 30'h3FFF_FFFF : qd_x[29:0];
            if (err_ff) begin
               num_in = '0;
               den_in = '0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff <= func_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      nm_ff   <= nm_in;
      dm_ff   <= dm_in;
      g_ff    <= g_in;
      qn_ff   <= qn_in;
      qd_ff   <= qd_in;
      neg_ff  <= neg_in;
      err_ff  <= err_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      if (state_ff == S_MUL && cnt_ff != 3'd0) begin
         p_ff[2'(cnt_ff - 3'd1)] <= prod;
      end
   end

   assign rsp_tdata = {2'b00, den_ff, num_ff};
   assign rsp_tuser = err_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response handshake open together");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready after accepting a request");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 64'd0))
      else $error("error response carries data");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (den_ff != 30'd0))
      else $error("zero denominator on good response");

endmodule

### design/ratalu_mul.sv
// shared signed multiplier with registered product
// depends on ratalu_pkg
module ratalu_mul
   import ratalu_pkg::*;
#(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic signed [W-1:0]   op_a,
   input  logic signed [W-1:0]   op_b,
   output logic signed [2*W-1:0] prod
);

   logic signed [2*W-1:0] prod_ff, prod_in;

   assign prod_in = (2*W)'(op_a) * (2*W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### design/ratalu_gcd.sv
// binary gcd unit, one shift or subtract step per cycle
// depends on ratalu_pkg
module ratalu_gcd
   import ratalu_pkg::*;
#(
   parameter int MW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] x_init,
   input  logic [MW-1:0] y_init,
   output logic          done,
   output logic [MW-1:0] g
);

   localparam int KW = $clog2(MW + 1);

   logic          busy_ff, busy_in;
   logic [MW-1:0] x_ff, x_in, y_ff, y_in;
   logic [KW-1:0] k_ff, k_in;

   assign done = busy_ff && (x_ff == y_ff);
   assign g    = x_ff << k_ff;

   always_comb begin
      busy_in = busy_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = x_init;
         y_in    = y_init;
         k_in    = '0;
      end else if (busy_ff) begin
         if (x_ff == y_ff) begin
            busy_in = 1'b0;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = x_ff - y_ff;
         end else begin
            y_in = y_ff - x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      k_ff <= k_in;
   end

endmodule

### design/ratalu_div.sv
// restoring divider, one quotient bit per cycle
// depends on ratalu_pkg
module ratalu_div
   import ratalu_pkg::*;
#(
   parameter int MW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] dividend,
   input  logic [MW-1:0] divisor,
   output logic          done,
   output logic [MW-1:0] quotient
);

   localparam int CW = $clog2(MW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] quo_ff, quo_in, dsr_ff, dsr_in;
   logic [MW:0]   rem_ff, rem_in, trial;

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff[MW-1:0], quo_ff[MW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(MW);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CW'(1);
            if (trial >= {1'b0, dsr_ff}) begin
               rem_in = trial - {1'b0, dsr_ff};
               quo_in = {quo_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[MW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

### sim/ratalu_checker.sv
// checker for the rational alu: watches request and response channels,
// predicts each reduced fraction and compares; depends on ratalu_pkg
module ratalu_checker
   import ratalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          error_count,
   output int          pending_count,
   output int          response_count
);

   typedef struct packed {
      logic [31:0] num;
      logic [29:0] den;
      logic        status;
   } fraction_type;

   fraction_type fraction_queue[$];

   function automatic longint gcd_of(longint x, longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_type reduce_fraction(logic [2:0] func, logic [63:0] data);
      longint an, ad, bn, bd, n, d, g;
      fraction_type r;
      an = longint'($signed(data[15:0]));
      ad = longint'($signed(data[31:16]));
      bn = longint'($signed(data[47:32]));
      bd = longint'($signed(data[63:48]));
      case (func)
         FUNC_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
         FUNC_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
         FUNC_MUL: begin n = an * bn; d = ad * bd; end
         FUNC_DIV: begin n = an * bd; d = ad * bn; end
         default: begin n = an; d = ad; end
      endcase
      r = '0;
      if (d == 0) begin
         r.status = 1'b1;
         return r;
      end
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n != 0) begin
         g = gcd_of(n < 0 ? -n : n, d);
         n = n / g;
         d = d / g;
      end
      if (n > 64'sd2147483647) n = 64'sd2147483647;
      if (n < -64'sd2147483648) n = -64'sd2147483648;
      if (d > 64'sd1073741823) d = 64'sd1073741823;
      r.num = n[31:0];
      r.den = d[29:0];
      return r;
   endfunction

   assign pending_count = fraction_queue.size();

   always @(posedge clock) begin
      fraction_type exp_r;
      if (reset) begin
         error_count <= 0;
         response_count <= 0;
         fraction_queue.delete();
      end else begin
         if (req_tvalid && req_tready)
            fraction_queue.push_back(reduce_fraction(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            response_count <= response_count + 1;
            if (fraction_queue.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               exp_r = fraction_queue.pop_front();
               if (rsp_tdata[31:0] !== exp_r.num || rsp_tdata[61:32] !== exp_r.den
                   || rsp_tdata[63:62] !== 2'b00 || rsp_tuser !== exp_r.status)
                  error_count <= error_count + 1;
               if (rsp_tdata[31:0] !== exp_r.num)
                  $error("res_num expected %0d got %0d", $signed(exp_r.num),
                         $signed(rsp_tdata[31:0]));
               if (rsp_tdata[61:32] !== exp_r.den)
                  $error("res_den expected %0d got %0d", exp_r.den, rsp_tdata[61:32]);
               if (rsp_tdata[63:62] !== 2'b00)
                  $error("pad expected 0 got %0d", rsp_tdata[63:62]);
               if (rsp_tuser !== exp_r.status)
                  $error("status expected %0d got %0d", exp_r.status, rsp_tuser);
            end
         end
      end
   end

endmodule

### sim/tb_rational_alu_with_reduction.sv
// testbench top for the rational alu: drives requests and response stalls,
// gives the verdict; depends on ratalu_pkg, ratalu_checker and the block
module tb_rational_alu_with_reduction;
   import ratalu_pkg::*;

   localparam int LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   int          error_count, pending_count, response_count;
   int          cycle_count = 0;
   bit          quiet_phase = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rational_alu_with_reduction dut (.*);

   ratalu_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset)
         rsp_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 17);

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h8001;
         3: return 16'h0000;
         4: return 16'(int'($urandom_range(8)) - 4);
         5, 6: return 16'($urandom_range(255)) ^ {16{$urandom_range(1) == 1}};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(logic [2:0] func, logic [15:0] an, logic [15:0] ad,
                               logic [15:0] bn, logic [15:0] bd);
      while (!quiet_phase && $urandom_range(99) < 17) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {bd, bn, ad, an};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [2:0] f;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed requests
      send_request(FUNC_NORM, 16'd6, -16'sd4, 16'd0, 16'd0);
      send_request(FUNC_NORM, 16'd0, -16'sd8, 16'd5, 16'd5);
      send_request(FUNC_NORM, 16'd3, 16'd0, 16'd1, 16'd1);
      send_request(FUNC_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
      send_request(FUNC_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
      send_request(FUNC_MUL, 16'h8000, 16'h8001, 16'h8000, 16'h7fff);
      send_request(FUNC_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
      send_request(FUNC_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(FUNC_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_request(FUNC_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_request(FUNC_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_request(FUNC_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
      send_request(FUNC_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
      send_request(3'd5, 16'd10, 16'd15, 16'd1, 16'd1);
      send_request(3'd6, -16'sd9, -16'sd3, 16'd1, 16'd1);
      send_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_request(FUNC_DIV, 16'h8000, 16'h0001, 16'h0001, 16'hffff);
      // hold off until the block has drained
      while (pending_count != 0) @(posedge clock);
      quiet_phase = 1;
      for (int i = 0; i < 950; i++) begin
         if (i == 150) quiet_phase = 0;
         f = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         send_request(f, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered all opcodes incl. unused ones, extreme and zero operands,");
      $display("%0d responses checked under random stalls", response_count);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
